// ----- rtl/delayed_event_timer_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// delayed_event_timer_table_unit_defines
// Assertion macros for the delayed event timer table.
// ----------------------------------------------------------------------------
`ifndef DELAYED_EVENT_TIMER_TABLE_UNIT_DEFINES_SVH
`define DELAYED_EVENT_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DETT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define DETT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DETT_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DETT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/dett_pkg.sv -----
// ----------------------------------------------------------------------------
// dett_pkg
// Types and codes shared by the delayed event timer table.
// ----------------------------------------------------------------------------
package dett_pkg;

  localparam logic [2:0] ACT_FLUSH   = 3'd0;
  localparam logic [2:0] ACT_ADD_JOB = 3'd1;
  localparam logic [2:0] ACT_DEL_JOB = 3'd2;
  localparam logic [2:0] ACT_ADD_SIG = 3'd3;
  localparam logic [2:0] ACT_DEL_SIG = 3'd4;
  localparam logic [2:0] ACT_TICK    = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_JOB    = 2'd1;
  localparam logic [1:0] KIND_SIG    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_NOENT = 2'd2;

  localparam logic [9:0] MS_PER_TICK_RESET = 10'd1;

  typedef logic [9:0] ms_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] task_handle;
    logic [31:0] timeout_ms;
    logic [31:0] signal_value;
    logic        periodic;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] expired_handle;
    logic [31:0] fired_signal;
    logic        last;
  } rsp_t;

endpackage

// ----- rtl/dett_stream_if.sv -----
// ----------------------------------------------------------------------------
// dett_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dett_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/delayed_event_timer_table_unit.sv -----
// ----------------------------------------------------------------------------
// delayed_event_timer_table_unit
// Job-delay and signal timer tables walked by one compare/subtract unit.
// ----------------------------------------------------------------------------
// Channels: req (sink, one action per beat), rsp (source, result beats, the
// closing status beat has last set), cfg (sink, ms_per_tick write, always
// ready; write only while idle).
// A req beat is taken only while the sequencer is idle. Flush and unknown
// actions go straight to the status beat. Add and delete walk the slots
// from 0 and stop at the first hit. A tick walks all job slots, then all
// signal slots, one slot per cycle through the shared subtract/compare
// unit while rsp does not hold up a waiting result beat.
// Results leave through one output register; when rsp stalls, the walk
// holds on the slot whose result is waiting and resumes once it moves.
// Reset clears all active bits, drops any pending beat and sets
// ms_per_tick to 1.
// ----------------------------------------------------------------------------
`include "delayed_event_timer_table_unit_defines.svh"

module delayed_event_timer_table_unit #(
  parameter int SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  dett_stream_if.sink   req,
  dett_stream_if.source rsp,
  dett_stream_if.sink   cfg
);
  import dett_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_TJOB   = 3'd2;
  localparam logic [2:0] S_TSIG   = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;

  logic [2:0]      state;
  logic [IW-1:0]   idx;
  ms_t             ms_per_tick;
  req_t            cur;
  logic [1:0]      cur_status;
  logic            out_valid;
  rsp_t            out_data;

  logic [SLOTS-1:0] job_active;
  logic [31:0]      job_handle    [SLOTS];
  logic [31:0]      job_remaining [SLOTS];
  logic [SLOTS-1:0] sig_active;
  logic [31:0]      sig_handle    [SLOTS];
  logic [31:0]      sig_code      [SLOTS];
  logic [31:0]      sig_period    [SLOTS];
  logic [31:0]      sig_remaining [SLOTS];
  logic [SLOTS-1:0] sig_repeat;

  logic [31:0] rem_sel;
  logic [32:0] diff;
  logic        expire;
  logic        can_emit;
  logic        slot_last;
  logic        job_hit;
  logic        sig_hit;
  logic        emit;
  logic        advance;
  rsp_t        emit_data;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    rem_sel   = (state == S_TJOB) ? job_remaining[idx] : sig_remaining[idx];
    diff      = {1'b0, rem_sel} - {23'd0, ms_per_tick};
    expire    = diff[32] | (diff[31:0] == 32'd0);
    can_emit  = !out_valid || rsp.ready;
    slot_last = (idx == LAST_IDX);
    job_hit   = job_active[idx] && (job_handle[idx] == cur.task_handle);
    sig_hit   = sig_active[idx] && (sig_handle[idx] == cur.task_handle) &&
                (sig_period[idx] == cur.timeout_ms);
    emit      = 1'b0;
    emit_data = '0;
    unique case (state)
      S_TJOB: begin
        if (job_active[idx] && expire) begin
          emit                     = 1'b1;
          emit_data.kind           = KIND_JOB;
          emit_data.expired_handle = job_handle[idx];
        end
      end
      S_TSIG: begin
        if (sig_active[idx] && expire) begin
          emit                     = 1'b1;
          emit_data.kind           = KIND_SIG;
          emit_data.expired_handle = sig_handle[idx];
          emit_data.fired_signal   = sig_code[idx];
        end
      end
      S_STATUS: begin
        emit             = 1'b1;
        emit_data.kind   = KIND_STATUS;
        emit_data.status = cur_status;
        emit_data.last   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    advance = !emit || can_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      out_valid   <= 1'b0;
      job_active  <= '0;
      sig_active  <= '0;
      ms_per_tick <= MS_PER_TICK_RESET;
      cur_status  <= ST_OK;
    end else begin
      if (cfg.valid) begin
        ms_per_tick <= cfg.data;
      end

      if (emit && can_emit) begin
        out_valid <= 1'b1;
        out_data  <= emit_data;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur        <= req.data;
            idx        <= '0;
            cur_status <= ST_OK;
            unique case (req.data.action)
              ACT_FLUSH: begin
                job_active <= '0;
                sig_active <= '0;
                state      <= S_STATUS;
              end
              ACT_ADD_JOB, ACT_DEL_JOB, ACT_ADD_SIG, ACT_DEL_SIG: begin
                state <= S_SCAN;
              end
              ACT_TICK: begin
                state <= S_TJOB;
              end
              default: begin
                state <= S_STATUS;
              end
            endcase
          end
        end

        S_SCAN: begin
          unique case (cur.action)
            ACT_ADD_JOB: begin
              if (!job_active[idx]) begin
                job_active[idx]    <= 1'b1;
                job_handle[idx]    <= cur.task_handle;
                job_remaining[idx] <= cur.timeout_ms;
                state              <= S_STATUS;
              end else if (slot_last) begin
                cur_status <= ST_BUSY;
                state      <= S_STATUS;
              end else begin
                idx <= idx + IW'(1);
              end
            end
            ACT_DEL_JOB: begin
              if (job_hit) begin
                job_active[idx] <= 1'b0;
                state           <= S_STATUS;
              end else if (slot_last) begin
                cur_status <= ST_NOENT;
                state      <= S_STATUS;
              end else begin
                idx <= idx + IW'(1);
              end
            end
            ACT_ADD_SIG: begin
              if (!sig_active[idx]) begin
                sig_active[idx]    <= 1'b1;
                sig_handle[idx]    <= cur.task_handle;
                sig_code[idx]      <= cur.signal_value;
                sig_period[idx]    <= cur.timeout_ms;
                sig_remaining[idx] <= cur.timeout_ms;
                sig_repeat[idx]    <= cur.periodic;
                state              <= S_STATUS;
              end else if (slot_last) begin
                cur_status <= ST_BUSY;
                state      <= S_STATUS;
              end else begin
                idx <= idx + IW'(1);
              end
            end
            ACT_DEL_SIG: begin
              if (sig_hit) begin
                sig_active[idx] <= 1'b0;
                state           <= S_STATUS;
              end else if (slot_last) begin
                cur_status <= ST_NOENT;
                state      <= S_STATUS;
              end else begin
                idx <= idx + IW'(1);
              end
            end
            default: begin
              state <= S_STATUS;
            end
          endcase
        end

        S_TJOB: begin
          if (advance) begin
            if (job_active[idx]) begin
              if (expire) begin
                job_active[idx] <= 1'b0;
              end else begin
                job_remaining[idx] <= diff[31:0];
              end
            end
            if (slot_last) begin
              idx   <= '0;
              state <= S_TSIG;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end

        S_TSIG: begin
          if (advance) begin
            if (sig_active[idx]) begin
              if (!expire) begin
                sig_remaining[idx] <= diff[31:0];
              end else if (sig_repeat[idx]) begin
                sig_remaining[idx] <= sig_period[idx];
              end else begin
                sig_active[idx] <= 1'b0;
              end
            end
            if (slot_last) begin
              state <= S_STATUS;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end

        S_STATUS: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DETT_ASSERT_SAME(a_last_is_status, clk, rst, out_valid && out_data.last, out_data.kind == KIND_STATUS, "last beat is not a status beat")
  `DETT_ASSERT_NEXT(a_status_exit, clk, rst, state == S_STATUS, (state == S_STATUS) || (state == S_IDLE), "status state left for a busy state")
  `DETT_ASSERT_SAME(a_idle_no_emit, clk, rst, state == S_IDLE, !emit, "result produced while idle")
  `DETT_ASSERT_NEXT(a_status_sent, clk, rst, (state == S_STATUS) && can_emit, out_valid && out_data.last, "status beat not loaded")

endmodule
